// File: sv/sha1c_pkg.sv
// shared types, constants and round helpers for the sha-1 compression core
`timescale 1ns / 1ps

package sha1c_pkg;

    typedef logic [31:0] t_word;

    localparam int WindowDepth = 16;
    localparam int ChainDepth  = 5;
    localparam int RoundCount  = 80;

    localparam logic [6:0] LastRound = 7'(RoundCount - 1);

    localparam t_word Iv0 = 32'h6745_2301;
    localparam t_word Iv1 = 32'hefcd_ab89;
    localparam t_word Iv2 = 32'h98ba_dcfe;
    localparam t_word Iv3 = 32'h1032_5476;
    localparam t_word Iv4 = 32'hc3d2_e1f0;

    localparam t_word K0 = 32'h5a82_7999;
    localparam t_word K1 = 32'h6ed9_eba1;
    localparam t_word K2 = 32'h8f1b_bcdc;
    localparam t_word K3 = 32'hca62_c1d6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_word;
        logic       start;
        logic       round_en;
        logic [6:0] round;
        logic       finish;
    } t_dp_cmd;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_word round_f(input logic [6:0] r, input t_word b,
                                      input t_word c, input t_word d);
        if (r < 7'd20) begin
            round_f = (b & c) | (~b & d);
        end else if (r < 7'd40) begin
            round_f = b ^ c ^ d;
        end else if (r < 7'd60) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

    function automatic t_word round_k(input logic [6:0] r);
        if (r < 7'd20) begin
            round_k = K0;
        end else if (r < 7'd40) begin
            round_k = K1;
        end else if (r < 7'd60) begin
            round_k = K2;
        end else begin
            round_k = K3;
        end
    endfunction

endpackage

// File: sv/sha1c_if.sv
// valid/ready channels for message words and digests
`timescale 1ns / 1ps

interface sha1c_word_if;
    logic                 valid;
    logic                 ready;
    sha1c_pkg::t_word     message_word;
    logic                 message_start;

    modport source (output valid, output message_word, output message_start, input ready);
    modport sink (input valid, input message_word, input message_start, output ready);
endinterface

interface sha1c_digest_if;
    logic                 valid;
    logic                 ready;
    sha1c_pkg::t_word     digest_a;
    sha1c_pkg::t_word     digest_b;
    sha1c_pkg::t_word     digest_c;
    sha1c_pkg::t_word     digest_d;
    sha1c_pkg::t_word     digest_e;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, output digest_e, input ready);
    modport sink (input valid, input digest_a, input digest_b, input digest_c,
                  input digest_d, input digest_e, output ready);
endinterface

// File: sv/sha1c_datapath.sv
// schedule window, working words, chaining words and digest register
`timescale 1ns / 1ps

module sha1c_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1c_pkg::t_dp_cmd i_cmd,
    input  sha1c_pkg::t_word   i_word,
    output sha1c_pkg::t_word   o_dig [sha1c_pkg::ChainDepth]
);

    sha1c_pkg::t_word r_w   [sha1c_pkg::WindowDepth];
    sha1c_pkg::t_word r_h   [sha1c_pkg::ChainDepth];
    sha1c_pkg::t_word r_v   [sha1c_pkg::ChainDepth];
    sha1c_pkg::t_word r_dig [sha1c_pkg::ChainDepth];

    sha1c_pkg::t_word n_exp;
    sha1c_pkg::t_word n_t;
    sha1c_pkg::t_word n_sum [sha1c_pkg::ChainDepth];

    // window holds w[r..r+15] at round r, so the next expanded word enters at the top
    assign n_exp = sha1c_pkg::rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);

    assign n_t = sha1c_pkg::rotl(r_v[0], 5)
               + sha1c_pkg::round_f(i_cmd.round, r_v[1], r_v[2], r_v[3])
               + r_v[4] + r_w[0] + sha1c_pkg::round_k(i_cmd.round);

    always_comb begin
        for (int i = 0; i < sha1c_pkg::ChainDepth; i++) begin
            n_sum[i] = r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word || i_cmd.round_en) begin
            for (int i = 0; i < sha1c_pkg::WindowDepth - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[sha1c_pkg::WindowDepth - 1] <= i_cmd.load_word ? i_word : n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_h[0] <= sha1c_pkg::Iv0;
            r_h[1] <= sha1c_pkg::Iv1;
            r_h[2] <= sha1c_pkg::Iv2;
            r_h[3] <= sha1c_pkg::Iv3;
            r_h[4] <= sha1c_pkg::Iv4;
        end else if (i_cmd.finish) begin
            r_h <= n_sum;
        end
        if (i_cmd.finish) begin
            r_dig <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_en) begin
            if (i_cmd.round == 7'd0) begin
                // first round works from the chaining words directly
                r_v[0] <= sha1c_pkg::rotl(r_h[0], 5)
                        + sha1c_pkg::round_f(7'd0, r_h[1], r_h[2], r_h[3])
                        + r_h[4] + r_w[0] + sha1c_pkg::K0;
                r_v[1] <= r_h[0];
                r_v[2] <= sha1c_pkg::rotl(r_h[1], 30);
                r_v[3] <= r_h[2];
                r_v[4] <= r_h[3];
            end else begin
                r_v[0] <= n_t;
                r_v[1] <= r_v[0];
                r_v[2] <= sha1c_pkg::rotl(r_v[1], 30);
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3];
            end
        end
    end

    assign o_dig = r_dig;

endmodule

// File: sv/sha1c_ctrl.sv
// word counting, round sequencing and output handshake
`timescale 1ns / 1ps

module sha1c_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_start,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sha1c_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUND,
        ST_FINISH
    } t_state;

    t_state     r_state;
    logic [3:0] r_word_cnt;
    logic [6:0] r_round;
    logic       r_out_valid;

    logic       n_accept;
    logic       n_slot_free;
    logic [3:0] n_cnt_eff;

    assign o_in_ready  = (r_state == ST_COLLECT);
    assign n_accept    = i_in_valid && o_in_ready;
    assign n_slot_free = !r_out_valid || i_out_ready;
    assign n_cnt_eff   = i_in_start ? 4'd0 : r_word_cnt;

    always_comb begin
        o_cmd.load_word = n_accept;
        o_cmd.start     = n_accept && i_in_start;
        o_cmd.round_en  = (r_state == ST_ROUND);
        o_cmd.round     = r_round;
        o_cmd.finish    = (r_state == ST_FINISH) && n_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_word_cnt  <= 4'd0;
            r_round     <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (n_accept) begin
                        r_word_cnt <= n_cnt_eff + 4'd1;
                        if (n_cnt_eff == 4'd15) begin
                            r_round <= 7'd0;
                            r_state <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == sha1c_pkg::LastRound) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (n_slot_free) begin
                        r_state <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= sha1c_pkg::LastRound))
        else $error("round index beyond last round");

    a_round_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == sha1c_pkg::LastRound) |=> (r_state == ST_FINISH))
        else $error("last round not followed by finish");

    a_finish_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished digest not presented");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_word |-> !o_cmd.round_en)
        else $error("word loaded during rounds");
`endif

endmodule

// File: sv/sha1_block_compression_core.sv
// top level of the sha-1 block compression core
`timescale 1ns / 1ps

// Takes a padded message as 32-bit big-endian words; message_start on a word
// reloads the standard initial value and makes that word the first of a new
// block. Words are taken one per cycle while collecting; after the sixteenth
// word of a block the core stops taking words while it runs the 80 rounds at one
// round per cycle, then folds the result into the chaining words in the finish
// state. The digest sits in an output register, so the next block's words are
// taken while it waits; a finished block waits in the finish state only if the
// previous digest has not yet been taken.
module sha1_block_compression_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha1c_word_if.sink     i_msg,
    sha1c_digest_if.source o_digest
);

    sha1c_pkg::t_dp_cmd w_cmd;
    sha1c_pkg::t_word   w_dig [sha1c_pkg::ChainDepth];

    sha1c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_msg.valid),
        .i_in_start  (i_msg.message_start),
        .o_in_ready  (i_msg.ready),
        .o_out_valid (o_digest.valid),
        .i_out_ready (o_digest.ready),
        .o_cmd       (w_cmd)
    );

    sha1c_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_word  (i_msg.message_word),
        .o_dig   (w_dig)
    );

    assign o_digest.digest_a = w_dig[0];
    assign o_digest.digest_b = w_dig[1];
    assign o_digest.digest_c = w_dig[2];
    assign o_digest.digest_d = w_dig[3];
    assign o_digest.digest_e = w_dig[4];

endmodule
